/* hw/rtl/cau_pkg.sv */
// types, widths and codes shared by the complex arithmetic unit
package cau_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DW = 16;
  localparam int QW = DW + 1;
  localparam int PW = 2 * DW + 2;
  localparam int DENW = 2 * DW;
  localparam int NW = 2 * DW + 1 + FRAC_BITS;
  localparam int CW = ((NW > DENW + QW) ? NW : DENW + QW) + 1;
  localparam int NSTEP = QW;
  localparam int LAST = NSTEP + 5;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;

  typedef struct packed {
    func_t func;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
  } in_t;

  typedef struct packed {
    logic signed [DW-1:0] res_re;
    logic signed [DW-1:0] res_im;
    logic div_by_zero;
    logic overflow;
  } out_t;

  typedef struct packed {
    func_t func;
    logic signed [DW:0] s_re;
    logic signed [DW:0] s_im;
    logic signed [2*DW-1:0] p_rr;
    logic signed [2*DW-1:0] p_ii;
    logic signed [2*DW-1:0] p_ri;
    logic signed [2*DW-1:0] p_ir;
    logic signed [2*DW-1:0] q_r;
    logic signed [2*DW-1:0] q_i;
  } prod_t;

  typedef struct packed {
    func_t func;
    logic signed [DW:0] s_re;
    logic signed [DW:0] s_im;
    logic signed [PW-1:0] m_re;
    logic signed [PW-1:0] m_im;
    logic signed [PW-1:0] n_re;
    logic signed [PW-1:0] n_im;
    logic [DENW-1:0] den;
  } comb_t;

  typedef struct packed {
    logic is_div;
    logic dbz;
    logic signed [PW-1:0] pre_re;
    logic signed [PW-1:0] pre_im;
    logic [DENW-1:0] d;
    logic [CW-1:0] r_re;
    logic [CW-1:0] r_im;
    logic [QW-1:0] q_re;
    logic [QW-1:0] q_im;
    logic neg_re;
    logic neg_im;
    logic big_re;
    logic big_im;
  } dv_t;

endpackage

/* hw/rtl/complex_arith_unit.sv */
// complex add, subtract, multiply and divide pipeline in signed q8.8
//
// usage:
//   in_valid/in_stall/in_data carry one request: a function code and two
//   complex operands. out_valid/out_stall/out_data return one result per
//   request, in order, with saturation and divide-by-zero flags.
//   one request is taken every cycle while in_stall is low. most of the
//   pipeline is the divider, a chain of 17 restoring steps, one quotient
//   bit per stage, after an input stage, a multiplier stage, a combine
//   stage, a magnitude stage and a range-check stage; a final stage applies
//   the sign, saturates and selects. every stage has its own valid bit and
//   moves when the stage after it is empty or moving, so bubbles are
//   squeezed out and the block keeps taking requests while a result waits.
//   when out_stall is high the output holds; in_stall rises only once all
//   stages are full.
//   reset (rst_n low, synchronous) empties the pipeline; no results are
//   produced until new requests arrive.
module complex_arith_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  cau_pkg::in_t     in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output cau_pkg::out_t    out_data
);

  logic [cau_pkg::LAST:0] v_r;
  logic [cau_pkg::LAST:0] adv;

  cau_pkg::in_t   in_r;
  cau_pkg::prod_t p_r, p_nxt;
  cau_pkg::comb_t c_r, c_nxt;
  cau_pkg::dv_t   dv_r [0:cau_pkg::NSTEP+1];
  cau_pkg::dv_t   dv0_nxt, dv1_nxt;
  cau_pkg::out_t  out_r, out_nxt;

  // stage advance chain
  always_comb begin
    adv[cau_pkg::LAST] = !v_r[cau_pkg::LAST] || !out_stall;
    for (int k = cau_pkg::LAST - 1; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = v_r[cau_pkg::LAST];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      for (int k = 1; k <= cau_pkg::LAST; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // multipliers and add/sub
  always_comb begin
    p_nxt.func = in_r.func;
    if (in_r.func == cau_pkg::FUNC_SUB) begin
      p_nxt.s_re = (cau_pkg::DW+1)'(in_r.a_re) - (cau_pkg::DW+1)'(in_r.b_re);
      p_nxt.s_im = (cau_pkg::DW+1)'(in_r.a_im) - (cau_pkg::DW+1)'(in_r.b_im);
    end else begin
      p_nxt.s_re = (cau_pkg::DW+1)'(in_r.a_re) + (cau_pkg::DW+1)'(in_r.b_re);
      p_nxt.s_im = (cau_pkg::DW+1)'(in_r.a_im) + (cau_pkg::DW+1)'(in_r.b_im);
    end
    p_nxt.p_rr = in_r.a_re * in_r.b_re;
    p_nxt.p_ii = in_r.a_im * in_r.b_im;
    p_nxt.p_ri = in_r.a_re * in_r.b_im;
    p_nxt.p_ir = in_r.a_im * in_r.b_re;
    p_nxt.q_r  = in_r.b_re * in_r.b_re;
    p_nxt.q_i  = in_r.b_im * in_r.b_im;
  end

  // cross terms and divisor
  always_comb begin
    c_nxt.func = p_r.func;
    c_nxt.s_re = p_r.s_re;
    c_nxt.s_im = p_r.s_im;
    c_nxt.m_re = cau_pkg::PW'(p_r.p_rr) - cau_pkg::PW'(p_r.p_ii);
    c_nxt.m_im = cau_pkg::PW'(p_r.p_ri) + cau_pkg::PW'(p_r.p_ir);
    c_nxt.n_re = cau_pkg::PW'(p_r.p_rr) + cau_pkg::PW'(p_r.p_ii);
    c_nxt.n_im = cau_pkg::PW'(p_r.p_ir) - cau_pkg::PW'(p_r.p_ri);
    c_nxt.den  = $unsigned(p_r.q_r) + $unsigned(p_r.q_i);
  end

  // non-divide result and divide magnitudes
  always_comb begin
    logic signed [cau_pkg::PW-1:0] t_re, t_im;
    logic [cau_pkg::PW-1:0] a_re, a_im;
    t_re = c_r.m_re + (c_r.m_re[cau_pkg::PW-1] ?
           cau_pkg::PW'((1 << cau_pkg::FRAC_BITS) - 1) : cau_pkg::PW'(0));
    t_im = c_r.m_im + (c_r.m_im[cau_pkg::PW-1] ?
           cau_pkg::PW'((1 << cau_pkg::FRAC_BITS) - 1) : cau_pkg::PW'(0));
    a_re = c_r.n_re[cau_pkg::PW-1] ? $unsigned(-c_r.n_re) : $unsigned(c_r.n_re);
    a_im = c_r.n_im[cau_pkg::PW-1] ? $unsigned(-c_r.n_im) : $unsigned(c_r.n_im);
    dv0_nxt = '0;
    dv0_nxt.is_div = (c_r.func == cau_pkg::FUNC_DIV);
    dv0_nxt.dbz    = (c_r.den == '0);
    if (c_r.func == cau_pkg::FUNC_MUL) begin
      dv0_nxt.pre_re = t_re >>> cau_pkg::FRAC_BITS;
      dv0_nxt.pre_im = t_im >>> cau_pkg::FRAC_BITS;
    end else begin
      dv0_nxt.pre_re = cau_pkg::PW'(c_r.s_re);
      dv0_nxt.pre_im = cau_pkg::PW'(c_r.s_im);
    end
    dv0_nxt.d      = c_r.den;
    dv0_nxt.r_re   = cau_pkg::CW'(a_re) << cau_pkg::FRAC_BITS;
    dv0_nxt.r_im   = cau_pkg::CW'(a_im) << cau_pkg::FRAC_BITS;
    dv0_nxt.neg_re = c_r.n_re[cau_pkg::PW-1];
    dv0_nxt.neg_im = c_r.n_im[cau_pkg::PW-1];
  end

  // quotient range check
  always_comb begin
    logic [cau_pkg::CW-1:0] lim;
    lim = cau_pkg::CW'(dv_r[0].d) << cau_pkg::QW;
    dv1_nxt = dv_r[0];
    dv1_nxt.big_re = (dv_r[0].r_re >= lim);
    dv1_nxt.big_im = (dv_r[0].r_im >= lim);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) in_r <= in_data;
    if (adv[1]) p_r <= p_nxt;
    if (adv[2]) c_r <= c_nxt;
    if (adv[3]) dv_r[0] <= dv0_nxt;
    if (adv[4]) dv_r[1] <= dv1_nxt;
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < cau_pkg::NSTEP; j++) begin : g_step
    cau_pkg::dv_t s_nxt;
    always_comb begin
      logic [cau_pkg::CW-1:0] ds;
      ds = cau_pkg::CW'(dv_r[j+1].d) << (cau_pkg::NSTEP - 1 - j);
      s_nxt = dv_r[j+1];
      if (dv_r[j+1].r_re >= ds) begin
        s_nxt.r_re = dv_r[j+1].r_re - ds;
        s_nxt.q_re[cau_pkg::NSTEP-1-j] = 1'b1;
      end
      if (dv_r[j+1].r_im >= ds) begin
        s_nxt.r_im = dv_r[j+1].r_im - ds;
        s_nxt.q_im[cau_pkg::NSTEP-1-j] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (adv[j+5]) dv_r[j+2] <= s_nxt;
    end
  end

  // sign, saturation and select
  always_comb begin
    cau_pkg::dv_t f;
    logic signed [cau_pkg::PW-1:0] v_re, v_im;
    logic o_re, o_im;
    f = dv_r[cau_pkg::NSTEP+1];
    v_re = f.neg_re ? -cau_pkg::PW'(f.q_re) : cau_pkg::PW'(f.q_re);
    v_im = f.neg_im ? -cau_pkg::PW'(f.q_im) : cau_pkg::PW'(f.q_im);
    if (f.is_div && f.big_re) v_re = f.neg_re ? -(cau_pkg::PW'(1) << cau_pkg::QW)
                                              : (cau_pkg::PW'(1) << cau_pkg::QW);
    if (f.is_div && f.big_im) v_im = f.neg_im ? -(cau_pkg::PW'(1) << cau_pkg::QW)
                                              : (cau_pkg::PW'(1) << cau_pkg::QW);
    if (!f.is_div) begin
      v_re = f.pre_re;
      v_im = f.pre_im;
    end
    o_re = 1'b0;
    o_im = 1'b0;
    out_nxt.res_re = v_re[cau_pkg::DW-1:0];
    out_nxt.res_im = v_im[cau_pkg::DW-1:0];
    if (v_re > cau_pkg::PW'(32767)) begin
      out_nxt.res_re = 16'sh7fff;
      o_re = 1'b1;
    end else if (v_re < -cau_pkg::PW'(32768)) begin
      out_nxt.res_re = 16'sh8000;
      o_re = 1'b1;
    end
    if (v_im > cau_pkg::PW'(32767)) begin
      out_nxt.res_im = 16'sh7fff;
      o_im = 1'b1;
    end else if (v_im < -cau_pkg::PW'(32768)) begin
      out_nxt.res_im = 16'sh8000;
      o_im = 1'b1;
    end
    out_nxt.overflow    = o_re || o_im;
    out_nxt.div_by_zero = 1'b0;
    if (f.is_div && f.dbz) begin
      out_nxt.res_re      = '0;
      out_nxt.res_im      = '0;
      out_nxt.overflow    = 1'b0;
      out_nxt.div_by_zero = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[cau_pkg::LAST]) out_r <= out_nxt;
  end

endmodule

/* sim/tb_complex_arith_unit.sv */
// testbench for the complex arithmetic unit: directed and random requests checked against a model
`timescale 1ns / 1ps

module tb_complex_arith_unit;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cau_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  cau_pkg::out_t out_data;

  cau_pkg::out_t result_q[$];
  int errors = 0;
  int cycle_count = 0;
  int hold_cycles = 0;
  int rx_wait = 0;
  bit rx_random = 1'b1;

  complex_arith_unit uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic longint sat_part(longint v, ref bit ovf);
    if (v > 32767) begin
      ovf = 1'b1;
      return 32767;
    end
    if (v < -32768) begin
      ovf = 1'b1;
      return -32768;
    end
    return v;
  endfunction

  function automatic cau_pkg::out_t complex_result(cau_pkg::in_t req);
    longint ar, ai, br, bi, re, im, den, scale;
    bit ovf;
    cau_pkg::out_t r;
    ar = req.a_re;
    ai = req.a_im;
    br = req.b_re;
    bi = req.b_im;
    scale = longint'(1) << cau_pkg::FRAC_BITS;
    re = 0;
    im = 0;
    ovf = 1'b0;
    r = '0;
    case (req.func)
      cau_pkg::FUNC_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      cau_pkg::FUNC_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      cau_pkg::FUNC_MUL: begin
        re = (ar * br - ai * bi) / scale;
        im = (ar * bi + ai * br) / scale;
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.div_by_zero = 1'b1;
        end else begin
          re = ((ar * br + ai * bi) * scale) / den;
          im = ((ai * br - ar * bi) * scale) / den;
        end
      end
    endcase
    re = sat_part(re, ovf);
    im = sat_part(im, ovf);
    r.res_re = re[15:0];
    r.res_im = im[15:0];
    r.overflow = ovf;
    return r;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("tb_complex_arith_unit: errors");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    cau_pkg::out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_data);
        errors++;
      end else begin
        exp_r = result_q.pop_front();
        if (out_data.res_re !== exp_r.res_re)
          $display("%0t res_re exp %h got %h", $time, exp_r.res_re, out_data.res_re);
        if (out_data.res_im !== exp_r.res_im)
          $display("%0t res_im exp %h got %h", $time, exp_r.res_im, out_data.res_im);
        if (out_data.div_by_zero !== exp_r.div_by_zero)
          $display("%0t div_by_zero exp %b got %b", $time, exp_r.div_by_zero,
                   out_data.div_by_zero);
        if (out_data.overflow !== exp_r.overflow)
          $display("%0t overflow exp %b got %b", $time, exp_r.overflow, out_data.overflow);
        if (out_data !== exp_r) errors++;
      end
    end
  end

  // receiver stall: forced hold, then a random wait after each result unless rx_random is clear
  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      out_stall <= 1'b1;
      rx_wait <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (!rx_random) begin
      out_stall <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      w = $urandom_range(0, 11);
      rx_wait <= (w > 0) ? w - 1 : 0;
      out_stall <= (w > 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_request(cau_pkg::in_t req, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    result_q.push_back(complex_result(req));
  endtask

  function automatic logic [15:0] edge_value();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return 16'($signed($urandom_range(0, 1023)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cau_pkg::in_t random_request();
    cau_pkg::in_t r;
    r.func = cau_pkg::func_t'($urandom_range(0, 3));
    r.a_re = edge_value();
    r.a_im = edge_value();
    r.b_re = edge_value();
    r.b_im = edge_value();
    if ($urandom_range(0, 9) == 0) begin
      r.b_re = '0;
      r.b_im = '0;
    end
    return r;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (result_q.size() != 0);
  endtask

  task automatic test_directed();
    cau_pkg::in_t r;
    logic [15:0] vals[5] = '{16'h8000, 16'h7fff, 16'h0000, 16'h0100, 16'hff00};
    for (int f = 0; f < 4; f++) begin
      for (int k = 0; k < 5; k++) begin
        r.func = cau_pkg::func_t'(f);
        r.a_re = vals[k];
        r.a_im = vals[(k + 1) % 5];
        r.b_re = vals[(k + 2) % 5];
        r.b_im = vals[(k + 3) % 5];
        send_request(r, 0);
      end
    end
    r = '{cau_pkg::FUNC_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000};
    send_request(r, 0);
    r = '{cau_pkg::FUNC_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000};
    send_request(r, 1);
    r = '{cau_pkg::FUNC_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000};
    send_request(r, 0);
    r = '{cau_pkg::FUNC_MUL, 16'hfffd, 16'h0003, 16'h0055, 16'h0001};
    send_request(r, 0);
    wait_drained();
  endtask

  task automatic test_random();
    for (int i = 0; i < 1100; i++)
      send_request(random_request(), $urandom_range(0, 3) == 0 ? $urandom_range(0, 11) : 0);
  endtask

  task automatic test_back_pressure();
    @(posedge clk);
    hold_cycles <= 80;
    for (int i = 0; i < 60; i++) send_request(random_request(), 0);
    wait_drained();
  endtask

  task automatic test_full_rate();
    rx_random = 1'b0;
    for (int i = 0; i < 60; i++) send_request(random_request(), 0);
    wait_drained();
    rx_random = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random();
    wait_drained();
    test_back_pressure();
    test_full_rate();
    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0 && result_q.size() == 0) begin
      $display("tb_complex_arith_unit: clean");
    end else begin
      $display("tb_complex_arith_unit: errors");
    end
    $finish;
  end
endmodule
